// ===== hdl/rdc_pkg.sv =====
// Package for the radix digit converter: state type, radix limits and the
// radix clamping function. No dependencies.

package rdc_pkg;

    // Bits of dividend consumed per cycle by the shared divider.
    localparam int STEP_BITS = 4;

    localparam logic [3:0] RADIX_MIN   = 4'd2;
    localparam logic [3:0] RADIX_MAX   = 4'd10;
    localparam logic [3:0] RADIX_RESET = 4'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_SHOW
    } t_state;

    // Radix values below two act as two, values above ten act as ten.
    function automatic logic [3:0] eff_radix(input logic [3:0] raw);
        logic [3:0] v_r;
        begin
            v_r = raw;
            if (raw < RADIX_MIN) begin
                v_r = RADIX_MIN;
            end else if (raw > RADIX_MAX) begin
                v_r = RADIX_MAX;
            end
            return v_r;
        end
    endfunction

endpackage

// ===== hdl/rdc_div_unit.sv =====
// Iterative divider of a wide unsigned value by a small radix, a few bits a cycle.
// Depends on rdc_pkg.

module rdc_div_unit
    import rdc_pkg::*;
#(
    parameter int QW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [QW-1:0] i_dividend,
    input  logic [3:0]    i_radix,
    output logic          o_done,
    output logic [QW-1:0] o_quotient,
    output logic [3:0]    o_remainder
);

    localparam int STEPS = QW / STEP_BITS;
    localparam int LW    = $clog2(STEPS + 1);

    logic [QW-1:0] r_work, n_work;
    logic [3:0]    r_rem, n_rem;
    logic [3:0]    r_div;
    logic [LW-1:0] r_left;
    logic          r_done;

    // Restoring long division: the remainder always stays below the radix,
    // so each step works on five bits only.
    always_comb begin
        logic [4:0] v_trial;
        n_rem  = r_rem;
        n_work = r_work;
        for (int i = 0; i < STEP_BITS; i++) begin
            v_trial = {n_rem, n_work[QW-1]};
            n_work  = {n_work[QW-2:0], 1'b0};
            if (v_trial >= {1'b0, r_div}) begin
                v_trial   = v_trial - {1'b0, r_div};
                n_work[0] = 1'b1;
            end
            n_rem = v_trial[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_done <= 1'b0;
            r_work <= '0;
        end else if (i_start) begin
            r_work <= i_dividend;
            r_left <= LW'(STEPS);
            r_done <= 1'b0;
        end else if (r_left != '0) begin
            r_work <= n_work;
            r_left <= r_left - LW'(1);
            r_done <= (r_left == LW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_radix;
        end else if (r_left != '0) begin
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_work;
    assign o_remainder = r_rem;

endmodule

// ===== hdl/radix_digit_converter.sv =====
// Operation: the number is divided by the radix once per digit, the remainders going to the
// digit store; the digits are then read back and emitted, most significant first.
// Throughput: one number at a time; the input stalls until the last digit has been taken and
// accepts again once the sequencer is back in idle, so a new number waits for the last one.
// Division time is set by the shared divider, which consumes four dividend bits per cycle.
// Reset (synchronous, active low) idles the sequencer, sets radix ten, keeps the digit store.

// Top level of the radix digit converter. Depends on rdc_pkg and rdc_div_unit.

module radix_digit_converter
    import rdc_pkg::*;
#(
    parameter int NUMBER_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_number,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_digit,
    output logic        o_last_digit
);

    // The dividend register is padded up to whole four-bit steps; the pad
    // bits are zero, so the quotient is unchanged.
    localparam int QW = ((NUMBER_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int AW = (NUMBER_BITS > 1) ? $clog2(NUMBER_BITS) : 1;
    localparam int CW = $clog2(NUMBER_BITS + 1);

    t_state        r_state, n_state;
    logic [3:0]    r_radix;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_pos;
    logic [3:0]    r_rdata;
    logic          r_last;
    logic [3:0]    r_store [NUMBER_BITS];

    logic          in_take;
    logic          out_take;
    logic          div_start;
    logic [QW-1:0] div_dividend;
    logic          div_done;
    logic [QW-1:0] div_quot;
    logic [3:0]    div_rem;
    logic          more_digits;

    assign in_take  = i_valid && !o_stall;
    assign out_take = o_valid && !i_stall;

    // The radix register keeps the raw value; clamping happens on use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_data;
        end
    end

    // Another digit is needed while the quotient is non-zero and the store
    // still has room.
    assign more_digits = (div_quot != '0) && (r_cnt != CW'(NUMBER_BITS - 1));

    // The first division takes the fresh number, masked to NUMBER_BITS; each
    // later one takes the quotient that the previous division left behind.
    assign div_dividend = (r_state == ST_IDLE) ? QW'(NUMBER_BITS'(i_number)) : div_quot;

    rdc_div_unit #(
        .QW (QW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_radix     (eff_radix(r_radix)),
        .o_done      (div_done),
        .o_quotient  (div_quot),
        .o_remainder (div_rem)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done && !more_digits) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_SHOW;
            end
            ST_SHOW: begin
                if (out_take) begin
                    n_state = r_last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_stall   = 1'b1;
        o_valid   = 1'b0;
        div_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall   = 1'b0;
                div_start = in_take;
            end
            ST_DIV: begin
                div_start = div_done && more_digits;
            end
            ST_READ: begin
                o_valid = 1'b0;
            end
            ST_SHOW: begin
                o_valid = 1'b1;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            if (in_take) begin
                r_cnt <= '0;
            end else if (r_state == ST_DIV && div_done) begin
                r_cnt <= r_cnt + CW'(1);
                // The digit just written is the most significant one so far.
                r_pos <= r_cnt[AW-1:0];
            end else if (r_state == ST_SHOW && out_take && !r_last) begin
                r_pos <= r_pos - AW'(1);
            end
        end
    end

    // Digit store: remainders are written least significant first and read
    // back in reverse order through a registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV && div_done) begin
            r_store[r_cnt[AW-1:0]] <= div_rem;
        end
        if (r_state == ST_READ) begin
            r_rdata <= r_store[r_pos];
            r_last  <= (r_pos == '0);
        end
    end

    assign o_digit      = r_rdata;
    assign o_last_digit = r_last;

endmodule

// ===== hdl/rdc_checker.sv =====
// Port-level checker for the radix digit converter, bound to the top level.
// Depends on radix_digit_converter.

module rdc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [3:0] o_digit,
    input logic       o_last_digit
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_digit) && $stable(o_last_digit))
        else $error("output transaction changed while stalled");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !o_valid)
        else $error("digit shown while the block accepts input");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input accepted twice without a conversion");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last_digit |=> !o_valid && !o_stall)
        else $error("block not idle after the final digit");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_digit |=> o_stall)
        else $error("input accepted before the final digit");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_digit      (o_digit),
    .o_last_digit (o_last_digit)
);
